>>> rtl/assert_macros.svh
// Assertion macros shared by the column post blitter RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while the reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication checked in the next cycle, switched off while the reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> rtl/pcpb_pkg.sv
// Shared types and constants of the column post blitter.
// Used by pcpb_csr, pcpb_parse and patch_column_post_blitter_core.
package pcpb_pkg;

   // Input item kinds.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_COLUMN  = 1'b1;

   // Top delta value that closes a column.
   localparam logic [7:0] END_MARK = 8'hFF;

   // Register file geometry.
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // Register indexes, word addressed.
   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_LEFT_OFFSET = 3'd2,
      REG_TOP_OFFSET  = 3'd3,
      REG_IMAGE_WIDTH = 3'd4,
      REG_FLIP        = 3'd5
   } reg_index_type;

   // Current register contents.
   typedef struct packed {
      logic signed [10:0] origin_x;
      logic signed [10:0] origin_y;
      logic signed [15:0] left_offset;
      logic signed [15:0] top_offset;
      logic        [10:0] image_width;
      logic               flip_horizontal;
   } csr_type;

   // Pixel request from the parser to the output stage.
   typedef struct packed {
      logic        hit;
      logic [15:0] address;
      logic [7:0]  index;
   } pixel_type;

endpackage

>>> rtl/pcpb_csr.sv
// Configuration registers of the column post blitter behind an APB-style port.
// Depends on pcpb_pkg.
module pcpb_csr
   import pcpb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output csr_type                   cfg
);

   csr_type       cfg_ff;
   csr_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Write decode: addresses past the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_ORIGIN_X:    cfg_in.origin_x        = pwdata[10:0];
            REG_ORIGIN_Y:    cfg_in.origin_y        = pwdata[10:0];
            REG_LEFT_OFFSET: cfg_in.left_offset     = pwdata[15:0];
            REG_TOP_OFFSET:  cfg_in.top_offset      = pwdata[15:0];
            REG_IMAGE_WIDTH: cfg_in.image_width     = pwdata[10:0];
            REG_FLIP:        cfg_in.flip_horizontal = pwdata[0];
            default:         cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode returns the raw register bits.
   always_comb begin
      unique case (reg_index)
         REG_ORIGIN_X:    prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.origin_x));
         REG_ORIGIN_Y:    prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.origin_y));
         REG_LEFT_OFFSET: prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.left_offset));
         REG_TOP_OFFSET:  prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.top_offset));
         REG_IMAGE_WIDTH: prdata = CSR_DATA_WIDTH'(cfg_ff.image_width);
         REG_FLIP:        prdata = CSR_DATA_WIDTH'(cfg_ff.flip_horizontal);
         default:         prdata = '0;
      endcase
   end

endmodule

>>> rtl/pcpb_parse.sv
// Column stream parser: post state machine, row and count tracking, and the
// screen position and framebuffer address of each index byte. Depends on pcpb_pkg.
module pcpb_parse
   import pcpb_pkg::*;
#(
   parameter int SCREEN_WIDTH    = 320,
   parameter int SCREEN_HEIGHT   = 200,
   parameter int MAX_IMAGE_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        column_start,
   input  logic [9:0]  column_number,
   input  logic [7:0]  data_byte,
   input  csr_type     cfg,
   output pixel_type   pix
);

   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam logic [12:0] MAX_W = 13'(MAX_IMAGE_WIDTH);

   typedef enum logic [5:0] {
      PH_ENDED     = 6'b000001,
      PH_DELTA     = 6'b000010,
      PH_LENGTH    = 6'b000100,
      PH_PAD_OPEN  = 6'b001000,
      PH_DATA      = 6'b010000,
      PH_PAD_CLOSE = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [11:0] row_ff, row_in;
   logic [7:0]  remaining_ff, remaining_in, remaining_dec;
   logic [11:0] dest_ff, dest_in, start_dest;
   logic        col_ok;
   logic [18:0] sx, sy;
   logic        on_screen;
   logic [31:0] address_full;

   // A start byte opens a new column, or closes it when out of the image.
   assign col_ok = (12'(column_number) < 12'(cfg.image_width)) &&
                   (13'(column_number) < MAX_W);
   assign start_dest = cfg.flip_horizontal ?
                       12'(cfg.image_width) - 12'd1 - 12'(column_number) :
                       12'(column_number);
   assign cur_phase = column_start ? (col_ok ? PH_DELTA : PH_ENDED) : phase_ff;
   assign dest_in   = (column_start && col_ok) ? start_dest : dest_ff;

   // Screen position of the pixel for the current index byte.
   assign sx = 19'(cfg.origin_x) - 19'(cfg.left_offset) + 19'(dest_ff);
   assign sy = 19'(cfg.origin_y) - 19'(cfg.top_offset) + 19'(row_ff);
   assign on_screen = !sx[18] && (sx < 19'(SCREEN_WIDTH)) &&
                      !sy[18] && (sy < 19'(SCREEN_HEIGHT));
   assign address_full = 32'(sy[YW-1:0]) * 32'(SCREEN_WIDTH) + 32'(sx[XW-1:0]);

   assign remaining_dec = remaining_ff - 8'd1;

   // Post state machine.
   always_comb begin
      phase_in     = cur_phase;
      row_in       = row_ff;
      remaining_in = remaining_ff;
      unique case (cur_phase)
         PH_DELTA: begin
            if (data_byte == END_MARK) begin
               phase_in = PH_ENDED;
            end else begin
               row_in   = 12'(data_byte);
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            remaining_in = data_byte;
            phase_in     = PH_PAD_OPEN;
         end
         PH_PAD_OPEN: begin
            phase_in = (remaining_ff != 8'd0) ? PH_DATA : PH_PAD_CLOSE;
         end
         PH_DATA: begin
            row_in       = row_ff + 12'd1;
            remaining_in = remaining_dec;
            phase_in     = (remaining_dec == 8'd0) ? PH_PAD_CLOSE : PH_DATA;
         end
         PH_PAD_CLOSE: begin
            phase_in = PH_DELTA;
         end
         default: begin
            phase_in = PH_ENDED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ENDED;
         row_ff       <= '0;
         remaining_ff <= '0;
         dest_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         remaining_ff <= remaining_in;
         dest_ff      <= dest_in;
      end
   end

   // Pixel request toward the palette and result register.
   assign pix.hit     = step && (cur_phase == PH_DATA) && on_screen;
   assign pix.address = address_full[15:0];
   assign pix.index   = data_byte;

endmodule

>>> rtl/patch_column_post_blitter_core.sv
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     opcode, column, byte, palette slot, color
// rsp       out        rsp_valid / rsp_ready     pixel_address, pixel_color
// csr       in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One item is accepted per cycle while req_ready is high; a pixel result appears
// in the cycle after its index byte, from the palette read and the result register.
// Reset clears the parser state, the registers and the result valid; the
// palette keeps its contents undefined until written.
// A held result stalls req_ready only when rsp_ready is low.
// Depends on pcpb_pkg, pcpb_csr, pcpb_parse and assert_macros.svh.
`include "assert_macros.svh"

module patch_column_post_blitter_core
   import pcpb_pkg::*;
#(
   parameter int SCREEN_WIDTH    = 320,
   parameter int SCREEN_HEIGHT   = 200,
   parameter int MAX_IMAGE_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic                      req_column_start,
   input  logic [9:0]                req_column_number,
   input  logic [7:0]                req_data_byte,
   input  logic [7:0]                req_palette_slot,
   input  logic [15:0]               req_palette_color,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_pixel_address,
   output logic [15:0]               rsp_pixel_color,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   csr_type     cfg;
   pixel_type   pix;
   logic        accept;
   logic        palette_accept;
   logic        column_accept;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] pixel_address_ff, pixel_address_in;
   logic [15:0] pixel_color_ff;
   logic [15:0] palette_mem [256];

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign palette_accept = accept && (req_opcode == OP_PALETTE);
   assign column_accept  = accept && (req_opcode == OP_COLUMN);

   pcpb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcpb_parse #(
      .SCREEN_WIDTH    (SCREEN_WIDTH),
      .SCREEN_HEIGHT   (SCREEN_HEIGHT),
      .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (column_accept),
      .column_start  (req_column_start),
      .column_number (req_column_number),
      .data_byte     (req_data_byte),
      .cfg           (cfg),
      .pix           (pix)
   );

   // Palette: written by palette items, read for each drawn pixel.
   always_ff @(posedge clock) begin
      if (palette_accept) begin
         palette_mem[req_palette_slot] <= req_palette_color;
      end
      if (pix.hit) begin
         pixel_color_ff <= palette_mem[pix.index];
      end
   end

   // Result register: loaded on a drawn pixel, cleared once taken.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      pixel_address_in = pixel_address_ff;
      if (accept) begin
         rsp_valid_in = pix.hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pix.hit) begin
         pixel_address_in = pix.address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_address_ff <= pixel_address_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = pixel_address_ff;
   assign rsp_pixel_color   = pixel_color_ff;

   // An empty result register always takes a new item.
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_valid_ff |-> req_ready)
   // A palette write never leaves a result behind.
   `ASSERT_NEXT(a_palette_no_result, clock, reset, palette_accept, !rsp_valid_ff)
   // A new result only follows an accepted column byte.
   `ASSERT_CLK(a_result_from_column, clock, reset, $rose(rsp_valid_ff) |-> $past(column_accept))

endmodule

>>> sim/patch_column_post_blitter_core_tb.sv
// Self-checking testbench for patch_column_post_blitter_core.
// Sends palette writes and column post streams, predicts every pixel in the
// testbench and checks results in order. Depends on pcpb_pkg and the RTL.
module patch_column_post_blitter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcpb_pkg::*;

   localparam int SCREEN_W     = 320;
   localparam int SCREEN_H     = 200;
   localparam int MAX_COLUMNS  = 1024;
   localparam int CLOCK_PERIOD = 10;
   localparam int RANDOM_ITEMS = 1100;
   localparam int NUM_PHASES   = 7;
   localparam int DRAIN_CYCLES = 4;
   localparam int END_CYCLES   = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 1000000;

   // One input item, one field per port.
   typedef struct packed {
      logic        opcode;
      logic        column_start;
      logic [9:0]  column_number;
      logic [7:0]  data_byte;
      logic [7:0]  palette_slot;
      logic [15:0] palette_color;
   } blit_item_type;

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] color;
   } expected_pixel_type;

   // Where the parser stands inside a column stream.
   typedef enum logic [5:0] {
      STREAM_IDLE    = 6'b000001,
      STREAM_TOP     = 6'b000010,
      STREAM_LEN     = 6'b000100,
      STREAM_PAD_IN  = 6'b001000,
      STREAM_PIXELS  = 6'b010000,
      STREAM_PAD_OUT = 6'b100000
   } stream_phase_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_opcode;
   logic                      req_column_start;
   logic [9:0]                req_column_number;
   logic [7:0]                req_data_byte;
   logic [7:0]                req_palette_slot;
   logic [15:0]               req_palette_color;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [15:0]               rsp_pixel_address;
   logic [15:0]               rsp_pixel_color;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // Predicted block state: registers, parser and palette.
   csr_type          cfg_mirror;
   stream_phase_type stream_phase;
   logic [11:0]      row_cursor;
   logic [7:0]       pixels_left;
   logic [11:0]      mirror_column;
   logic [15:0]      palette_mirror [256];

   expected_pixel_type expected_pixels [$];
   logic [7:0]         stream_bytes [$];

   int error_count   = 0;
   int item_count    = 0;
   int palette_count = 0;
   int pixel_count   = 0;
   int setting_count = 0;
   int cycle_count   = 0;
   int hold_left;
   int pal_mix_pct;
   bit send_idle_on;
   bit recv_idle_on;

   patch_column_post_blitter_core #(
      .SCREEN_WIDTH(SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H),
      .MAX_IMAGE_WIDTH(MAX_COLUMNS)
   ) u_dut (.*);

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Gap length in cycles: mostly none or short, a few long.
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // A column stream byte; the column number only matters on a start.
   function automatic blit_item_type column_byte(input bit start, input int column,
                                                 input int value);
      blit_item_type it;
      it.opcode        = OP_COLUMN;
      it.column_start  = start;
      it.column_number = start ? 10'(column) : 10'($urandom_range(0, 1023));
      it.data_byte     = 8'(value);
      it.palette_slot  = 8'($urandom_range(0, 255));
      it.palette_color = 16'($urandom_range(0, 65535));
      return it;
   endfunction

   // A palette write with random content in the fields it ignores.
   function automatic blit_item_type palette_write(input int slot, input int color);
      blit_item_type it;
      it.opcode        = OP_PALETTE;
      it.column_start  = 1'($urandom_range(0, 1));
      it.column_number = 10'($urandom_range(0, 1023));
      it.data_byte     = 8'($urandom_range(0, 255));
      it.palette_slot  = 8'(slot);
      it.palette_color = 16'(color);
      return it;
   endfunction

   // Advance the predicted parser by one accepted item and queue any pixel.
   task automatic predict_item(input blit_item_type it);
      int                 sx;
      int                 sy;
      int                 addr;
      int                 mirrored;
      int                 ox;
      int                 oy;
      int                 lo;
      int                 to;
      expected_pixel_type px;
      if (it.opcode == OP_PALETTE) begin
         palette_mirror[it.palette_slot] = it.palette_color;
      end else begin
         // A start always opens a new column, or closes it when out of range.
         if (it.column_start) begin
            if (it.column_number >= cfg_mirror.image_width ||
                int'(it.column_number) >= MAX_COLUMNS) begin
               stream_phase = STREAM_IDLE;
            end else begin
               mirrored = int'(it.column_number);
               if (cfg_mirror.flip_horizontal) begin
                  mirrored = int'(cfg_mirror.image_width) - 1 - int'(it.column_number);
               end
               mirror_column = mirrored[11:0];
               stream_phase  = STREAM_TOP;
            end
         end
         case (stream_phase)
            STREAM_TOP: begin
               if (it.data_byte == END_MARK) begin
                  stream_phase = STREAM_IDLE;
               end else begin
                  row_cursor   = {4'b0, it.data_byte};
                  stream_phase = STREAM_LEN;
               end
            end
            STREAM_LEN: begin
               pixels_left  = it.data_byte;
               stream_phase = STREAM_PAD_IN;
            end
            STREAM_PAD_IN: begin
               stream_phase = (pixels_left != 0) ? STREAM_PIXELS : STREAM_PAD_OUT;
            end
            STREAM_PIXELS: begin
               // Screen position from origin, offsets and the post position.
               ox = $signed(cfg_mirror.origin_x);
               oy = $signed(cfg_mirror.origin_y);
               lo = $signed(cfg_mirror.left_offset);
               to = $signed(cfg_mirror.top_offset);
               sx = ox - lo + int'(mirror_column);
               sy = oy - to + int'(row_cursor);
               if (sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H) begin
                  addr       = sy * SCREEN_W + sx;
                  px.address = addr[15:0];
                  px.color   = palette_mirror[it.data_byte];
                  expected_pixels.push_back(px);
               end
               row_cursor  = row_cursor + 12'd1;
               pixels_left = pixels_left - 8'd1;
               if (pixels_left == 0) stream_phase = STREAM_PAD_OUT;
            end
            STREAM_PAD_OUT: begin
               stream_phase = STREAM_TOP;
            end
            default: begin
               stream_phase = STREAM_IDLE;
            end
         endcase
      end
   endtask

   // Offer one item after a random gap and wait until it is accepted.
   task automatic send_item(input blit_item_type it);
      int gap;
      gap = pick_gap(send_idle_on);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= it.opcode;
      req_column_start  <= it.column_start;
      req_column_number <= it.column_number;
      req_data_byte     <= it.data_byte;
      req_palette_slot  <= it.palette_slot;
      req_palette_color <= it.palette_color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(it);
      item_count++;
      if (it.opcode == OP_PALETTE) palette_count++;
   endtask

   // Send the first keep bytes of stream_bytes as one column, start on the first.
   task automatic send_stream(input int column, input int keep);
      int i;
      for (i = 0; i < stream_bytes.size() && i < keep; i++) begin
         if (i > 0 && $urandom_range(0, 99) < pal_mix_pct) begin
            send_item(palette_write($urandom_range(0, 255), $urandom_range(0, 65535)));
         end
         send_item(column_byte(i == 0, column, stream_bytes[i]));
      end
   endtask

   // Fill stream_bytes with a well-formed column of random posts.
   task automatic build_column(input int posts);
      int p;
      int i;
      int len;
      int r;
      stream_bytes.delete();
      for (p = 0; p < posts; p++) begin
         r = $urandom_range(0, 99);
         stream_bytes.push_back(8'((r < 70) ? $urandom_range(0, 60) : $urandom_range(0, 254)));
         r = $urandom_range(0, 999);
         if (r < 100)      len = 0;
         else if (r < 850) len = $urandom_range(1, 8);
         else if (r < 995) len = $urandom_range(9, 40);
         else              len = $urandom_range(41, 255);
         stream_bytes.push_back(8'(len));
         stream_bytes.push_back(8'($urandom_range(0, 255)));
         for (i = 0; i < len; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
         stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
      stream_bytes.push_back(END_MARK);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Stop offering items and wait until every expected pixel has come.
   task automatic wait_drained();
      release_req();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_ORIGIN_X:    cfg_mirror.origin_x        = value[10:0];
         REG_ORIGIN_Y:    cfg_mirror.origin_y        = value[10:0];
         REG_LEFT_OFFSET: cfg_mirror.left_offset     = value[15:0];
         REG_TOP_OFFSET:  cfg_mirror.top_offset      = value[15:0];
         REG_IMAGE_WIDTH: cfg_mirror.image_width     = value[10:0];
         REG_FLIP:        cfg_mirror.flip_horizontal = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write the whole register set once the block is idle.
   task automatic apply_setting(input int ox, input int oy, input int lo, input int to,
                                input int width, input int flip);
      wait_drained();
      write_register(REG_ORIGIN_X, ox);
      write_register(REG_ORIGIN_Y, oy);
      write_register(REG_LEFT_OFFSET, lo);
      write_register(REG_TOP_OFFSET, to);
      write_register(REG_IMAGE_WIDTH, width);
      write_register(REG_FLIP, flip);
      setting_count++;
   endtask

   // Every palette entry is written before any index byte is parsed.
   task automatic test_palette_fill();
      int slot;
      for (slot = 0; slot < 256; slot++) begin
         if (slot == 0)        send_item(palette_write(slot, 16'hFFFF));
         else if (slot == 255) send_item(palette_write(slot, 16'h0000));
         else                  send_item(palette_write(slot, $urandom_range(0, 65535)));
      end
   endtask

   // Two pixels from one post, then an empty post, then the end mark.
   task automatic test_basic_posts();
      apply_setting(10, 5, 0, 0, 4, 0);
      stream_bytes = '{8'd0, 8'd2, 8'hFF, 8'd0, 8'd255, 8'd0,
                       8'd3, 8'd0, 8'd0, 8'd0, END_MARK};
      send_stream(0, stream_bytes.size());
   endtask

   // Pixels on and just past the screen edges, and the register extremes.
   task automatic test_screen_edges();
      apply_setting(319, 199, 0, 0, 2, 0);
      // Last column, last row; the second pixel of the post falls below.
      stream_bytes = '{8'd0, 8'd2, 8'd0, 8'd1, 8'd2, 8'd0, END_MARK};
      send_stream(0, stream_bytes.size());
      // One column past the right edge.
      stream_bytes = '{8'd0, 8'd1, 8'd0, 8'd3, 8'd0, END_MARK};
      send_stream(1, stream_bytes.size());
      // The far column, mirrored, lands on the left edge of the bottom row.
      apply_setting(-1024, -1024, -1024, -1024, 1024, 1);
      stream_bytes = '{8'd199, 8'd1, 8'd0, 8'd4, 8'd0, END_MARK};
      send_stream(1023, stream_bytes.size());
      // Largest offsets push the image off the top left.
      apply_setting(1023, 1023, 32767, 32767, 1024, 0);
      stream_bytes = '{8'd0, 8'd1, 8'd0, 8'd5, 8'd0, END_MARK};
      send_stream(0, stream_bytes.size());
      apply_setting(-1024, 1023, -32768, -32768, 1024, 1);
      send_stream(0, stream_bytes.size());
   endtask

   // Irregular streams: stray bytes, restarts, bad columns, live updates.
   task automatic test_stream_cases();
      apply_setting(20, 20, 0, 0, 8, 0);
      // A byte after the column has ended is ignored.
      send_item(column_byte(0, 0, 8'h05));
      // A new start in the middle of a post drops the open post.
      stream_bytes = '{8'd2, 8'd3, 8'd0, 8'd10};
      send_stream(1, stream_bytes.size());
      stream_bytes = '{8'd0, 8'd1, 8'd0, 8'd11, 8'd0, END_MARK};
      send_stream(2, stream_bytes.size());
      // A column at the image width draws nothing.
      stream_bytes = '{8'd0, 8'd1, 8'd0, 8'd12, 8'd0, END_MARK};
      send_stream(8, stream_bytes.size());
      // Register and palette writes inside an open post apply from the next pixel.
      stream_bytes = '{8'd0, 8'd3, 8'd0, 8'd13};
      send_stream(3, stream_bytes.size());
      wait_drained();
      write_register(REG_LEFT_OFFSET, -5);
      write_register(REG_FLIP, 1);
      send_item(palette_write(14, 16'hA5A5));
      send_item(column_byte(0, 0, 8'd14));
      send_item(column_byte(0, 0, 8'd14));
      send_item(column_byte(0, 0, 8'd0));
      send_item(column_byte(0, 0, END_MARK));
      // With an image width of zero every column is outside the image.
      wait_drained();
      write_register(REG_IMAGE_WIDTH, 0);
      stream_bytes = '{8'd0, 8'd1, 8'd0, 8'd15, 8'd0, END_MARK};
      send_stream(0, stream_bytes.size());
   endtask

   // Hold the result side off while a long post keeps the input busy.
   task automatic test_backpressure();
      int i;
      apply_setting(10, 0, 0, 0, 4, 0);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      hold_left    = HOLD_CYCLES;
      stream_bytes = '{8'd0, 8'd255, 8'd17};
      for (i = 0; i < 255; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(8'd0);
      stream_bytes.push_back(END_MARK);
      send_stream(1, stream_bytes.size());
      // The sender pauses until every pixel is out, then carries on.
      release_req();
      while (expected_pixels.size() != 0) @(posedge clock);
      build_column(2);
      send_stream(2, stream_bytes.size());
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // Random columns over several register settings, mostly well formed.
   task automatic test_random_streams();
      int phase;
      int sent;
      int quota;
      int kind;
      int col;
      int width;
      int mark;
      quota       = RANDOM_ITEMS / NUM_PHASES;
      pal_mix_pct = 4;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == NUM_PHASES - 1) begin
            apply_setting(int'($urandom_range(0, 2047)) - 1024,
                          int'($urandom_range(0, 2047)) - 1024,
                          int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          $urandom_range(0, 1024), $urandom_range(0, 1));
         end else begin
            apply_setting(int'($urandom_range(0, 340)) - 20,
                          int'($urandom_range(0, 160)) - 10,
                          int'($urandom_range(0, 40)) - 20,
                          int'($urandom_range(0, 40)) - 20,
                          ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(1, 80),
                          phase % 2);
         end
         sent = 0;
         while (sent < quota) begin
            send_idle_on = ($urandom_range(0, 4) != 0);
            recv_idle_on = ($urandom_range(0, 4) != 0);
            width        = cfg_mirror.image_width;
            kind         = $urandom_range(0, 99);
            if (width == 0 && kind < 88) kind = 88;
            if (width >= MAX_COLUMNS && kind >= 88 && kind < 94) kind = 94;
            mark = item_count;
            if (kind < 88) begin
               // Whole column, or one cut short by the next start.
               col = $urandom_range(0, width - 1);
               build_column($urandom_range(0, 3));
               if (kind < 78) send_stream(col, stream_bytes.size());
               else           send_stream(col, $urandom_range(1, stream_bytes.size()));
            end else if (kind < 94) begin
               col = $urandom_range(width, MAX_COLUMNS - 1);
               build_column(1);
               send_stream(col, stream_bytes.size());
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  send_item(column_byte(0, 0, $urandom_range(0, 255)));
               end
            end
            sent += item_count - mark;
            if ($urandom_range(0, 49) == 0) begin
               release_req();
               while (expected_pixels.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(recv_idle_on);
         end
      end
   end

   // Compare each accepted pixel with the oldest prediction.
   always @(posedge clock) begin : pixel_checker
      expected_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("Unexpected pixel: pixel_address %0d pixel_color 0x%04h",
                   rsp_pixel_address, rsp_pixel_color);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixel_count++;
            if (rsp_pixel_address !== want.address) begin
               $error("pixel_address: expected %0d, actual %0d",
                      want.address, rsp_pixel_address);
               error_count++;
            end
            if (rsp_pixel_color !== want.color) begin
               $error("pixel_color: expected 0x%04h, actual 0x%04h",
                      want.color, rsp_pixel_color);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still expected",
                  cycle_count, expected_pixels.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_PALETTE;
      req_column_start  = 1'b0;
      req_column_number = '0;
      req_data_byte     = '0;
      req_palette_slot  = '0;
      req_palette_color = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      hold_left         = 0;
      pal_mix_pct       = 0;
      send_idle_on      = 1'b1;
      recv_idle_on      = 1'b1;
      cfg_mirror        = '0;
      stream_phase      = STREAM_IDLE;
      row_cursor        = '0;
      pixels_left       = '0;
      mirror_column     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_palette_fill();
      test_basic_posts();
      test_screen_edges();
      test_stream_cases();
      test_backpressure();
      test_random_streams();

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d palette writes) across %0d register settings.",
               item_count, palette_count, setting_count);
      $display("Checked %0d pixels, with a %0d-cycle result hold-off and live updates.",
               pixel_count, HOLD_CYCLES);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
